// ===== src/udp_challenge_response_auth_macros.svh =====
// Assertion macros for the challenge/response authentication block.
`ifndef UDP_CHALLENGE_RESPONSE_AUTH_MACROS_SVH
`define UDP_CHALLENGE_RESPONSE_AUTH_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define UCRA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("udp_challenge_response_auth: assertion failure");
// Consequent must hold in the cycle after the antecedent.
`define UCRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("udp_challenge_response_auth: assertion failure");
`else
`define UCRA_ASSERT_SAME(label, clk, rst, ante, cons)
`define UCRA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/udp_cra_pkg.sv =====
// Shared types, constants and helpers of the challenge/response authentication block.
package udp_cra_pkg;

   localparam int NUM_DEVICES_DEFAULT = 16;

   localparam int LOAD_IDX_W = 4;
   localparam int LOAD_SLOTS = 2 ** LOAD_IDX_W;
   localparam int WORD_W     = 32;
   localparam int DWORD_W    = 64;
   localparam int HASH_W     = 8;
   localparam int KIND_W     = 8;
   localparam int LEN_W      = 16;
   localparam int ETH_W      = 16;
   localparam int PROTO_W    = 8;
   localparam int VERDICT_W  = 2;

   localparam int MOD_DIGIT_W = 8;
   localparam int MOD_STEPS   = WORD_W / MOD_DIGIT_W;
   localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

   localparam int REQ_DATA_W = 344;
   localparam int RSP_DATA_W = 136;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_PACKET = 1'b1;

   localparam logic [KIND_W-1:0] MSG_CHAL_REQ  = 8'h00;
   localparam logic [KIND_W-1:0] MSG_CHALLENGE = 8'h01;
   localparam logic [KIND_W-1:0] MSG_RESPONSE  = 8'h02;
   localparam logic [KIND_W-1:0] MSG_ACK       = 8'h03;

   localparam logic [ETH_W-1:0]   ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [PROTO_W-1:0] IP_PROTO_UDP   = 8'h11;
   localparam logic [LEN_W-1:0]   LEN_MIN_ETH    = 16'd14;
   localparam logic [LEN_W-1:0]   LEN_MIN_IP     = 16'd34;
   localparam logic [LEN_W-1:0]   LEN_MIN_AUTH   = 16'd82;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_PASS  = 2'd0,
      VERDICT_DROP  = 2'd1,
      VERDICT_TX    = 2'd2,
      VERDICT_ABORT = 2'd3
   } verdict_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_SUM,
      ST_FOLD
   } state_type;

   typedef struct packed {
      logic [DWORD_W-1:0] challenges;
      logic [DWORD_W-1:0] response_a;
      logic [DWORD_W-1:0] response_b;
   } entry_type;

   typedef struct packed {
      logic                  en;
      logic [LOAD_IDX_W-1:0] index;
      entry_type             data;
   } tbl_wr_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [HASH_W-1:0] wr_data;
   } hash_cmd_type;

   // Last field (frame_length) in the lowest bits.
   typedef struct packed {
      logic [3:0]            pad;
      logic [DWORD_W-1:0]    load_response_b;
      logic [DWORD_W-1:0]    load_response_a;
      logic [DWORD_W-1:0]    load_challenges;
      logic [LOAD_IDX_W-1:0] load_index;
      logic [WORD_W-1:0]     random_word;
      logic [WORD_W-1:0]     reply_hash;
      logic [WORD_W-1:0]     device_ident;
      logic [KIND_W-1:0]     message_kind;
      logic [PROTO_W-1:0]    ip_proto;
      logic [ETH_W-1:0]      ether_kind;
      logic [LEN_W-1:0]      frame_length;
   } req_data_type;

   typedef struct packed {
      logic [WORD_W-1:0] out_ident;
      logic [WORD_W-1:0] out_random;
      logic [WORD_W-1:0] out_challenge_b;
      logic [WORD_W-1:0] out_challenge_a;
      logic [KIND_W-1:0] out_message_kind;
   } rsp_data_type;

   typedef struct packed {
      logic [WORD_W-1:0]  random_word;
      logic [WORD_W-1:0]  reply_hash;
      logic [WORD_W-1:0]  device_ident;
      logic [KIND_W-1:0]  message_kind;
      logic [PROTO_W-1:0] ip_proto;
      logic [ETH_W-1:0]   ether_kind;
      logic [LEN_W-1:0]   frame_length;
   } pkt_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// ===== src/udp_cra_mod_unit.sv =====
// Remainder of a 32-bit word by the device count: residue folding, then a reciprocal multiply.
module udp_cra_mod_unit #(
   parameter int NUM_DEVICES = udp_cra_pkg::NUM_DEVICES_DEFAULT,
   localparam int DEV_AW = udp_cra_pkg::addr_width(NUM_DEVICES)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [udp_cra_pkg::WORD_W-1:0]  dividend,
   output logic                            busy,
   output logic                            done,
   output logic [DEV_AW-1:0]               remainder
);
   import udp_cra_pkg::*;

   localparam int ACC_W    = 20;
   localparam int FOLD_W   = 17;
   localparam int RECIP_SH = 27;
   localparam int PROD_W   = FOLD_W + RECIP_SH;

   localparam logic [ACC_W-1:0]  RES_8   = ACC_W'((2 ** 8) % NUM_DEVICES);
   localparam logic [ACC_W-1:0]  RES_16  = ACC_W'((2 ** 16) % NUM_DEVICES);
   localparam logic [ACC_W-1:0]  RES_24  = ACC_W'((2 ** 24) % NUM_DEVICES);
   localparam logic [PROD_W-1:0] RECIP   =
      PROD_W'(((2 ** RECIP_SH) + NUM_DEVICES - 1) / NUM_DEVICES);
   localparam logic [FOLD_W-1:0] DIVISOR = FOLD_W'(NUM_DEVICES);

   localparam logic [MOD_CNT_W-1:0] STEP_FOLD_HI = MOD_CNT_W'(0);
   localparam logic [MOD_CNT_W-1:0] STEP_FOLD_LO = MOD_CNT_W'(1);
   localparam logic [MOD_CNT_W-1:0] STEP_QUOT    = MOD_CNT_W'(2);
   localparam logic [MOD_CNT_W-1:0] STEP_REM     = MOD_CNT_W'(3);
   localparam logic [MOD_CNT_W-1:0] CNT_LAST     = MOD_CNT_W'(MOD_STEPS - 1);

   logic [WORD_W-1:0]    word_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic [FOLD_W-1:0]    quot_ff;
   logic [DEV_AW-1:0]    rem_ff;
   logic [ACC_W-1:0]     fold_hi;
   logic [FOLD_W-1:0]    fold_lo;
   logic [PROD_W-1:0]    prod;
   logic [FOLD_W-1:0]    diff;
   logic [MOD_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   // byte residues summed, then the top bits folded once more: below 2**17
   assign fold_hi = ACC_W'(word_ff[31:24]) * RES_24 + ACC_W'(word_ff[23:16]) * RES_16
                  + ACC_W'(word_ff[15:8]) * RES_8 + ACC_W'(word_ff[7:0]);
   assign fold_lo = FOLD_W'(acc_ff[ACC_W-1:16]) * FOLD_W'(RES_16) + FOLD_W'(acc_ff[15:0]);
   // quotient exact for values below 2**17 and up to 1024 devices
   assign prod    = PROD_W'(acc_ff[FOLD_W-1:0]) * RECIP;
   assign diff    = acc_ff[FOLD_W-1:0] - quot_ff * DIVISOR;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + MOD_CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         word_ff <= dividend;
      end else if (busy_ff) begin
         unique case (cnt_ff)
            STEP_FOLD_HI: acc_ff  <= fold_hi;
            STEP_FOLD_LO: acc_ff  <= ACC_W'(fold_lo);
            STEP_QUOT:    quot_ff <= prod[PROD_W-1:RECIP_SH];
            STEP_REM:     rem_ff  <= diff[DEV_AW-1:0];
         endcase
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/udp_cra_entry_table.sv =====
// Challenge/response entry table: synchronous memory with one write and one read port and per-entry valid bits.
module udp_cra_entry_table #(
   parameter int NUM_DEVICES = udp_cra_pkg::NUM_DEVICES_DEFAULT,
   localparam int DEV_AW = udp_cra_pkg::addr_width(NUM_DEVICES)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  udp_cra_pkg::tbl_wr_type wr,
   input  logic                    rd_en,
   input  logic [DEV_AW-1:0]       rd_entry,
   output udp_cra_pkg::entry_type  rd_data
);
   import udp_cra_pkg::*;

   localparam int TBL_DEPTH = (NUM_DEVICES < LOAD_SLOTS) ? NUM_DEVICES : LOAD_SLOTS;
   localparam int TBL_AW    = addr_width(TBL_DEPTH);

   entry_type            mem [TBL_DEPTH];
   logic [TBL_DEPTH-1:0] valid_ff;
   entry_type            rd_data_ff;
   logic                 rd_ok_ff;
   logic                 wr_hit;
   logic [TBL_AW-1:0]    wr_addr;
   logic                 rd_hit;
   logic [TBL_AW-1:0]    rd_addr;

   assign wr_hit  = wr.en && (32'(wr.index) < 32'(TBL_DEPTH));
   assign wr_addr = wr.index[TBL_AW-1:0];
   assign rd_hit  = 32'(rd_entry) < 32'(TBL_DEPTH);
   assign rd_addr = rd_entry[TBL_AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_hit) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ok_ff <= 1'b0;
      end else if (rd_en) begin
         rd_ok_ff <= rd_hit && valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem[wr_addr] <= wr.data;
      end
      if (rd_en && rd_hit) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // unloaded or out-of-table entries read as zero
   assign rd_data = rd_ok_ff ? rd_data_ff : '0;

endmodule

// ===== src/udp_cra_hash_store.sv =====
// Per-device issued hash store with a clearing sweep after reset.
module udp_cra_hash_store #(
   parameter int NUM_DEVICES = udp_cra_pkg::NUM_DEVICES_DEFAULT,
   localparam int DEV_AW = udp_cra_pkg::addr_width(NUM_DEVICES)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  udp_cra_pkg::hash_cmd_type         cmd,
   input  logic [DEV_AW-1:0]                 addr,
   output logic [udp_cra_pkg::HASH_W-1:0]    rd_data,
   output logic                              clear_done
);
   import udp_cra_pkg::*;

   localparam logic [DEV_AW-1:0] ADDR_LAST = DEV_AW'(NUM_DEVICES - 1);

   logic [HASH_W-1:0] mem [NUM_DEVICES];
   logic [HASH_W-1:0] rd_data_ff;
   logic              clr_busy_ff;
   logic [DEV_AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == ADDR_LAST) begin
            clr_busy_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + DEV_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.wr_en) begin
         mem[addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_done = !clr_busy_ff;

endmodule

// ===== src/udp_challenge_response_auth.sv =====
// Top level of the UDP challenge/response authentication filter.
// Input beats on req_*: tuser selects a table load (0) or a packet descriptor (1).
// A load beat writes one entry of the challenge table in the accepting cycle and
// produces no result; the next beat may follow in the following cycle.
// A packet beat produces exactly one result beat on rsp_*: tuser carries the
// verdict, tdata the reply fields. The entry index random mod NUM_DEVICES is
// formed by a remainder unit and handed over, after which the table and hash
// memories are read, the hash sum is registered and then folded into the result
// register. The next beat is taken once the result is in the result register, so
// the block takes no new beat while a packet is in progress.
// The result register holds its beat while rsp_tready is low; the block may
// accept loads and one further packet meanwhile and then waits in its last step.
// After reset the hash store is swept to zero; req_tready stays low until the
// sweep is done.
`include "udp_challenge_response_auth_macros.svh"

module udp_challenge_response_auth #(
   parameter int NUM_DEVICES = udp_cra_pkg::NUM_DEVICES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // frame_length, ether_kind, ip_proto, message_kind, device_ident, reply_hash,
   // random_word, load_index, load_challenges, load_response_a, load_response_b
   input  logic [udp_cra_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_message_kind, out_challenge_a, out_challenge_b, out_random, out_ident
   output logic [udp_cra_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // verdict
   output logic [udp_cra_pkg::VERDICT_W-1:0]    rsp_tuser
);
   import udp_cra_pkg::*;

   localparam int DEV_AW = addr_width(NUM_DEVICES);

   state_type         state_ff;
   state_type         state_in;
   req_data_type      req_data;
   pkt_type           item_ff;
   logic              req_accept;
   logic              mod_start;
   logic              mod_busy;
   logic              mod_done;
   logic [DEV_AW-1:0] mod_rem;
   tbl_wr_type        tbl_wr;
   logic              tbl_rd;
   entry_type         entry;
   hash_cmd_type      hash_cmd;
   logic [HASH_W-1:0] hash_rd;
   logic              clear_done;
   logic [WORD_W-1:0] dev;
   logic              dev_ok;
   logic              sum_en;
   logic [DWORD_W-1:0] sum_ff;
   logic [WORD_W-1:0] fold_a;
   logic [LEN_W-1:0]  fold_b;
   logic [HASH_W-1:0] hash_val;
   logic              out_free;
   logic              emit;
   logic              hash_wr;
   verdict_type       verdict_in;
   rsp_data_type      rsp_in;
   logic              rsp_valid_ff;
   rsp_data_type      rsp_data_ff;
   verdict_type       rsp_user_ff;

   assign req_data   = req_data_type'(req_tdata);
   assign req_accept = req_tvalid && req_tready;
   assign dev        = item_ff.device_ident - WORD_W'(1);
   assign dev_ok     = dev < WORD_W'(NUM_DEVICES);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clear_done) state_in = ST_IDLE;
         ST_IDLE:  if (req_accept && req_tuser == REQ_PACKET) state_in = ST_MOD;
         ST_MOD:   if (mod_done) state_in = ST_READ;
         ST_READ:  state_in = ST_SUM;
         ST_SUM:   state_in = ST_FOLD;
         ST_FOLD:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      mod_start  = req_accept && (req_tuser == REQ_PACKET);
      tbl_rd     = (state_ff == ST_READ);
      sum_en     = (state_ff == ST_SUM);
      emit       = (state_ff == ST_FOLD) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mod_start) begin
         item_ff.frame_length <= req_data.frame_length;
         item_ff.ether_kind   <= req_data.ether_kind;
         item_ff.ip_proto     <= req_data.ip_proto;
         item_ff.message_kind <= req_data.message_kind;
         item_ff.device_ident <= req_data.device_ident;
         item_ff.reply_hash   <= req_data.reply_hash;
         item_ff.random_word  <= req_data.random_word;
      end
   end

   assign tbl_wr.en                  = req_accept && (req_tuser == REQ_LOAD);
   assign tbl_wr.index               = req_data.load_index;
   assign tbl_wr.data.challenges     = req_data.load_challenges;
   assign tbl_wr.data.response_a     = req_data.load_response_a;
   assign tbl_wr.data.response_b     = req_data.load_response_b;

   udp_cra_mod_unit #(
      .NUM_DEVICES(NUM_DEVICES)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (req_data.random_word),
      .busy     (mod_busy),
      .done     (mod_done),
      .remainder(mod_rem)
   );

   udp_cra_entry_table #(
      .NUM_DEVICES(NUM_DEVICES)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .rd_en   (tbl_rd),
      .rd_entry(mod_rem),
      .rd_data (entry)
   );

   assign hash_cmd.rd_en   = tbl_rd && dev_ok;
   assign hash_cmd.wr_en   = emit && hash_wr;
   assign hash_cmd.wr_data = hash_val;

   udp_cra_hash_store #(
      .NUM_DEVICES(NUM_DEVICES)
   ) u_hash (
      .clock     (clock),
      .reset     (reset),
      .cmd       (hash_cmd),
      .addr      (dev[DEV_AW-1:0]),
      .rd_data   (hash_rd),
      .clear_done(clear_done)
   );

   always_ff @(posedge clock) begin
      if (sum_en) begin
         sum_ff <= entry.response_a + entry.response_b + DWORD_W'(item_ff.random_word);
      end
   end

   // folding by halves down to one byte, carries dropped
   assign fold_a   = sum_ff[WORD_W-1:0] + sum_ff[DWORD_W-1:WORD_W];
   assign fold_b   = fold_a[15:0] + fold_a[31:16];
   assign hash_val = fold_b[7:0] + fold_b[15:8];

   always_comb begin
      rsp_in                  = '0;
      rsp_in.out_message_kind = item_ff.message_kind;
      verdict_in              = VERDICT_PASS;
      hash_wr                 = 1'b0;
      priority if (item_ff.frame_length < LEN_MIN_ETH) begin
         verdict_in = VERDICT_DROP;
      end else if (item_ff.ether_kind != ETHERTYPE_IPV4) begin
         verdict_in = VERDICT_PASS;
      end else if (item_ff.frame_length < LEN_MIN_IP) begin
         verdict_in = VERDICT_DROP;
      end else if (item_ff.ip_proto != IP_PROTO_UDP) begin
         verdict_in = VERDICT_PASS;
      end else if (item_ff.frame_length < LEN_MIN_AUTH) begin
         verdict_in = VERDICT_DROP;
      end else if (item_ff.message_kind == MSG_CHAL_REQ) begin
         verdict_in              = VERDICT_TX;
         rsp_in.out_message_kind = MSG_CHALLENGE;
         rsp_in.out_challenge_a  = entry.challenges[DWORD_W-1:WORD_W];
         rsp_in.out_challenge_b  = entry.challenges[WORD_W-1:0];
         rsp_in.out_random       = item_ff.random_word
                                   ^ (entry.response_a[WORD_W-1:0]
                                      | entry.response_b[WORD_W-1:0]);
         rsp_in.out_ident        = item_ff.device_ident;
         hash_wr                 = dev_ok;
      end else if (item_ff.message_kind == MSG_RESPONSE) begin
         if (!dev_ok) begin
            verdict_in = VERDICT_ABORT;
         end else if (item_ff.reply_hash == WORD_W'(hash_rd)) begin
            verdict_in              = VERDICT_TX;
            rsp_in.out_message_kind = MSG_ACK;
            rsp_in.out_ident        = item_ff.device_ident;
         end else begin
            verdict_in = VERDICT_PASS;
         end
      end else begin
         verdict_in = VERDICT_PASS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_in;
         rsp_user_ff <= verdict_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `UCRA_ASSERT_SAME(a_mod_busy_in_mod, clock, reset, mod_busy, state_ff == ST_MOD)
   `UCRA_ASSERT_SAME(a_ready_after_clear, clock, reset, req_tready, clear_done)
   `UCRA_ASSERT_NEXT(a_fold_emits, clock, reset, emit, rsp_tvalid && state_ff == ST_IDLE)

endmodule
